// ----- sv/b58_pkg.sv -----
// ----------------------------------------------------------------------------
// Base58 encoder package
// Shared payload types, controller/datapath command and status structs,
// constants and the digit arithmetic and alphabet functions.
// ----------------------------------------------------------------------------
`default_nettype none

package b58_pkg;

  localparam int unsigned B58_MAX_LEN_DEF = 64;
  localparam logic [6:0]  B58_MAX_LEN_RST = 7'd64;
  localparam logic [6:0]  B58_CH_ONE      = 7'h31;
  localparam logic [5:0]  B58_BASE        = 6'd58;
  localparam logic [9:0]  B58_RECIP       = 10'd565;
  localparam int unsigned B58_SHIFT       = 15;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } b58_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
    logic       overflow;
  } b58_out_t;

  typedef enum logic [1:0] {
    RD_FIRST = 2'd0,
    RD_NEXT  = 2'd1,
    RD_DIG   = 2'd2
  } b58_rd_sel_e;

  typedef struct packed {
    logic        accept;
    logic        step;
    logic        setup;
    logic        emit_one;
    logic        emit_dig;
    logic        emit_err;
    logic        clear;
    b58_rd_sel_e rd_sel;
  } b58_cmd_t;

  typedef struct packed {
    logic active;
    logic last;
    logic ovf;
    logic ones_nz;
    logic digs_nz;
    logic ones_last;
    logic digs_last;
    logic digs_left_nz;
    logic out_free;
  } b58_status_t;

  typedef struct packed {
    logic [7:0] quo;
    logic [5:0] rem;
  } b58_qr_t;

  // The reciprocal is exact for every value below 57 * 256 + 256.
  function automatic b58_qr_t b58_divmod(input logic [13:0] n);
    logic [23:0] prod;
    logic [7:0]  quo;
    logic [13:0] back;
    b58_qr_t     res;
    prod     = 24'(n) * 24'(B58_RECIP);
    quo      = prod[B58_SHIFT +: 8];
    back     = 14'(quo) * 14'(B58_BASE);
    res.quo  = quo;
    res.rem  = 6'(n - back);
    return res;
  endfunction

  function automatic logic [6:0] b58_alpha(input logic [5:0] d);
    logic [6:0] dx;
    logic [6:0] ch;
    dx = 7'(d);
    if (d < 6'd9) begin
      ch = 7'h31 + dx;
    end else if (d < 6'd17) begin
      ch = 7'h41 + dx - 7'd9;
    end else if (d < 6'd22) begin
      ch = 7'h4A + dx - 7'd17;
    end else if (d < 6'd33) begin
      ch = 7'h50 + dx - 7'd22;
    end else if (d < 6'd44) begin
      ch = 7'h61 + dx - 7'd33;
    end else if (d < 6'd58) begin
      ch = 7'h6D + dx - 7'd44;
    end else begin
      ch = B58_CH_ONE;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- sv/b58_ctrl.sv -----
// ----------------------------------------------------------------------------
// Base58 encoder controller
// Sequences input acceptance, the digit update loop and character emission.
// ----------------------------------------------------------------------------
`default_nettype none

module b58_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire b58_pkg::b58_status_t st_i,
  output b58_pkg::b58_cmd_t        cmd_o
);
  import b58_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_UPDATE  = 7'b0000010,
    S_FINISH  = 7'b0000100,
    S_ONES    = 7'b0001000,
    S_DIG_RD  = 7'b0010000,
    S_DIG_OUT = 7'b0100000,
    S_ERR     = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_FIRST;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.rd_sel = RD_NEXT;
        if (st_i.active) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!st_i.last) begin
          state_d = S_IDLE;
        end else if (st_i.ovf) begin
          state_d = S_ERR;
        end else begin
          cmd_o.setup = 1'b1;
          if (st_i.ones_nz) begin
            state_d = S_ONES;
          end else if (st_i.digs_nz) begin
            state_d = S_DIG_RD;
          end else begin
            cmd_o.clear = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_ONES: begin
        if (st_i.out_free) begin
          cmd_o.emit_one = 1'b1;
          if (st_i.ones_last) begin
            if (st_i.digs_left_nz) begin
              state_d = S_DIG_RD;
            end else begin
              cmd_o.clear = 1'b1;
              state_d = S_IDLE;
            end
          end
        end
      end
      S_DIG_RD: begin
        cmd_o.rd_sel = RD_DIG;
        state_d = S_DIG_OUT;
      end
      S_DIG_OUT: begin
        cmd_o.rd_sel = RD_DIG;
        if (st_i.out_free) begin
          cmd_o.emit_dig = 1'b1;
          if (st_i.digs_last) begin
            cmd_o.clear = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_DIG_RD;
          end
        end
      end
      S_ERR: begin
        if (st_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          cmd_o.clear = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/b58_datapath.sv -----
// ----------------------------------------------------------------------------
// Base58 encoder datapath
// Digit store, multiply-by-256 digit update unit, string counters, limit
// register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b58_datapath #(
  parameter int unsigned MAX_LEN = b58_pkg::B58_MAX_LEN_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [6:0]          cfg_data_i,
  input  wire b58_pkg::b58_in_t    in_data_i,
  input  wire b58_pkg::b58_cmd_t   cmd_i,
  output b58_pkg::b58_status_t     st_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output b58_pkg::b58_out_t        out_data_o
);
  import b58_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned LW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

  logic [5:0]    mem [MAX_LEN];
  logic [5:0]    rdata_q;
  logic [AW-1:0] raddr;

  logic [6:0]    max_len_q, max_len_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] lead_q, lead_d;
  logic          still_q, still_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] ones_left_q, ones_left_d;
  logic [CW-1:0] digs_left_q, digs_left_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    carry_q, carry_d;
  logic [CW-1:0] j_q, j_d;
  logic          last_q, last_d;
  logic [AW-1:0] dig_idx_q, dig_idx_d;
  b58_out_t      out_data_q, out_data_d;

  logic [LW-1:0] ml_ext;
  logic [CW-1:0] lim;
  logic [CW-1:0] jn;
  logic          jlt;
  logic [5:0]    cur_dig;
  b58_qr_t       qr;
  logic [CW-1:0] ones;
  logic [CW-1:0] room;
  logic [CW-1:0] digs;
  logic [CW-1:0] count_m1;
  logic          out_free;

  always_comb begin
    ml_ext = LW'(max_len_q);
    if (max_len_q == 7'd0) begin
      lim = CW'(1);
    end else if (ml_ext > LW'(MAX_LEN)) begin
      lim = MAX_CNT;
    end else begin
      lim = CW'(ml_ext);
    end
  end

  assign jn       = j_q + CW'(1);
  assign jlt      = (j_q < count_q);
  assign cur_dig  = jlt ? rdata_q : 6'd0;
  assign qr       = b58_divmod({cur_dig, carry_q});
  assign ones     = (lead_q < lim) ? lead_q : lim;
  assign room     = lim - ones;
  assign digs     = (count_q < room) ? count_q : room;
  assign count_m1 = count_q - CW'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_FIRST: raddr = '0;
      RD_NEXT:  raddr = jn[AW-1:0];
      RD_DIG:   raddr = dig_idx_q;
      default:  raddr = '0;
    endcase
  end

  always_comb begin
    st_o.active       = !ovf_q && (jlt || (carry_q != 8'd0));
    st_o.last         = last_q;
    st_o.ovf          = ovf_q;
    st_o.ones_nz      = (ones != '0);
    st_o.digs_nz      = (digs != '0);
    st_o.ones_last    = (ones_left_q == CW'(1));
    st_o.digs_last    = (digs_left_q == CW'(1));
    st_o.digs_left_nz = (digs_left_q != '0);
    st_o.out_free     = out_free;
  end

  always_comb begin
    max_len_d   = max_len_q;
    count_d     = count_q;
    lead_d      = lead_q;
    still_d     = still_q;
    ovf_d       = ovf_q;
    ones_left_d = ones_left_q;
    digs_left_d = digs_left_q;
    out_valid_d = out_valid_q;
    carry_d     = carry_q;
    j_d         = j_q;
    last_d      = last_q;
    dig_idx_d   = dig_idx_q;
    out_data_d  = out_data_q;

    if (cfg_we_i) begin
      max_len_d = cfg_data_i;
    end

    if (cmd_i.accept) begin
      carry_d = in_data_i.data_byte;
      last_d  = in_data_i.last_byte;
      j_d     = '0;
      if (!ovf_q) begin
        if ((in_data_i.data_byte == 8'd0) && still_q) begin
          if (lead_q < MAX_CNT) begin
            lead_d = lead_q + CW'(1);
          end
        end else begin
          still_d = 1'b0;
        end
      end
    end

    if (cmd_i.step) begin
      carry_d = qr.quo;
      j_d     = jn;
      if (jn > count_q) begin
        count_d = jn;
      end
      if (jn >= lim) begin
        ovf_d = 1'b1;
      end
    end

    if (cmd_i.setup) begin
      ones_left_d = ones;
      digs_left_d = digs;
      dig_idx_d   = count_m1[AW-1:0];
    end

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.emit_one) begin
      out_valid_d          = 1'b1;
      out_data_d.out_char  = B58_CH_ONE;
      out_data_d.last_char = (ones_left_q == CW'(1)) && (digs_left_q == '0);
      out_data_d.overflow  = 1'b0;
      ones_left_d          = ones_left_q - CW'(1);
    end

    if (cmd_i.emit_dig) begin
      out_valid_d          = 1'b1;
      out_data_d.out_char  = b58_alpha(rdata_q);
      out_data_d.last_char = (digs_left_q == CW'(1));
      out_data_d.overflow  = 1'b0;
      digs_left_d          = digs_left_q - CW'(1);
      dig_idx_d            = dig_idx_q - AW'(1);
    end

    if (cmd_i.emit_err) begin
      out_valid_d          = 1'b1;
      out_data_d.out_char  = B58_CH_ONE;
      out_data_d.last_char = 1'b1;
      out_data_d.overflow  = 1'b1;
    end

    if (cmd_i.clear) begin
      count_d = '0;
      lead_d  = '0;
      still_d = 1'b1;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      mem[j_q[AW-1:0]] <= qr.rem;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= B58_MAX_LEN_RST;
      count_q     <= '0;
      lead_q      <= '0;
      still_q     <= 1'b1;
      ovf_q       <= 1'b0;
      ones_left_q <= '0;
      digs_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      max_len_q   <= max_len_d;
      count_q     <= count_d;
      lead_q      <= lead_d;
      still_q     <= still_d;
      ovf_q       <= ovf_d;
      ones_left_q <= ones_left_d;
      digs_left_q <= digs_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q    <= carry_d;
    j_q        <= j_d;
    last_q     <= last_d;
    dig_idx_q  <= dig_idx_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_step_not_overflowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !ovf_q)
    else $error("Digit update issued after overflow.");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("Digit count exceeds store depth.");

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_one || cmd_i.emit_dig || cmd_i.emit_err) |-> out_free)
    else $error("Item emitted into an occupied output register.");

  a_digit_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_dig |-> (digs_left_q != '0))
    else $error("Digit emitted with none left.");

  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (count_q == '0) && !ovf_q && still_q)
    else $error("String state not cleared.");

endmodule

`default_nettype wire

// ----- sv/base58_encoder_core.sv -----
// ----------------------------------------------------------------------------
// Base58 encoder core
// Encodes a byte string into Bitcoin-alphabet base58 characters.
// ----------------------------------------------------------------------------
// Bytes arrive one item at a time, most significant first, with last_byte on
// the final one. Each byte is accepted in S_IDLE; S_UPDATE then steps through
// every stored base58 digit and each new digit it creates, up to the
// configured limit, and S_FINISH closes the update. The single digit update
// unit handles one digit per cycle, reading the next digit from the store
// while it writes back the current one. After the last byte the leading '1'
// characters leave at one item per cycle while the output is not stalled,
// and each remaining digit needs its own store read before it is sent.
// If the digit count reaches the limit, a single error item is sent instead.
// The input stalls while a string update or the emission is in progress; a
// finished character may wait in the output register while the next byte is
// taken. The max_len register is written through the configuration channel,
// which is always ready, and should be changed only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module base58_encoder_core #(
  parameter int unsigned MAX_LEN = b58_pkg::B58_MAX_LEN_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [6:0]        cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire b58_pkg::b58_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output b58_pkg::b58_out_t      out_data_o
);
  import b58_pkg::*;

  b58_cmd_t    cmd;
  b58_status_t st;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  b58_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  b58_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- test/base58_encoder_core_test.sv -----
// ----------------------------------------------------------------------------
// Base58 encoder core testbench
// Sends byte strings through the encoder and checks every character against
// an independent base58 digit model or typed text. A short table of hand-picked
// strings is followed by random strings under several character limits. Both
// channels pause at random.
// ----------------------------------------------------------------------------
module base58_encoder_core_test;
  import b58_pkg::*;

  localparam int unsigned MAX_LEN      = B58_MAX_LEN_DEF;
  localparam int unsigned RANDOM_BYTES = 480;
  localparam int unsigned PHASE_BYTES  = 60;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned N_ROWS       = 23;

  // A row with n_typed set to zero is checked against the digit model.
  typedef struct packed {
    logic        set_cfg;
    logic [6:0]  cfg_val;
    logic [7:0]  data;
    logic        fin;
    logic [2:0]  n_typed;
    logic        err;
    logic [31:0] text;
  } dir_row_t;

  dir_row_t directed_rows [N_ROWS] = '{
    '{1'b0, 7'd0,   8'h00, 1'b1, 3'd1, 1'b0, "1"},
    '{1'b0, 7'd0,   8'h01, 1'b1, 3'd1, 1'b0, "2"},
    '{1'b0, 7'd0,   8'hFF, 1'b1, 3'd2, 1'b0, "5Q"},
    '{1'b0, 7'd0,   8'h39, 1'b1, 3'd1, 1'b0, "z"},
    '{1'b0, 7'd0,   8'h3A, 1'b1, 3'd2, 1'b0, "21"},
    '{1'b0, 7'd0,   8'h00, 1'b0, 3'd0, 1'b0, 32'd0},
    '{1'b0, 7'd0,   8'h00, 1'b0, 3'd0, 1'b0, 32'd0},
    '{1'b0, 7'd0,   8'hFF, 1'b1, 3'd4, 1'b0, "115Q"},
    '{1'b0, 7'd0,   8'hFF, 1'b0, 3'd0, 1'b0, 32'd0},
    '{1'b0, 7'd0,   8'hFF, 1'b1, 3'd0, 1'b0, 32'd0},
    '{1'b0, 7'd0,   8'h80, 1'b0, 3'd0, 1'b0, 32'd0},
    '{1'b0, 7'd0,   8'h00, 1'b1, 3'd0, 1'b0, 32'd0},
    '{1'b1, 7'd1,   8'h00, 1'b1, 3'd1, 1'b0, "1"},
    '{1'b0, 7'd0,   8'h05, 1'b1, 3'd1, 1'b1, "1"},
    '{1'b0, 7'd0,   8'h00, 1'b0, 3'd0, 1'b0, 32'd0},
    '{1'b0, 7'd0,   8'h00, 1'b1, 3'd1, 1'b0, "1"},
    '{1'b1, 7'd0,   8'h07, 1'b1, 3'd1, 1'b1, "1"},
    '{1'b1, 7'd127, 8'hFF, 1'b1, 3'd2, 1'b0, "5Q"},
    '{1'b1, 7'd2,   8'h00, 1'b0, 3'd0, 1'b0, 32'd0},
    '{1'b0, 7'd0,   8'hFF, 1'b1, 3'd1, 1'b1, "1"},
    '{1'b0, 7'd0,   8'h00, 1'b0, 3'd0, 1'b0, 32'd0},
    '{1'b0, 7'd0,   8'h00, 1'b0, 3'd0, 1'b0, 32'd0},
    '{1'b0, 7'd0,   8'h00, 1'b1, 3'd2, 1'b0, "11"}
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data  = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  b58_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  b58_out_t   out_data;

  string alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  logic [5:0]  digits [MAX_LEN];
  int unsigned n_digits  = 0;
  int unsigned n_ones    = 0;
  logic        leading   = 1'b1;
  logic        rejected  = 1'b0;
  logic [6:0]  limit_reg = B58_MAX_LEN_RST;

  b58_out_t    new_chars [$];
  b58_out_t    chars_due [$];
  logic        calm      = 1'b0;
  int unsigned n_bytes   = 0;
  int unsigned n_strings = 0;
  int unsigned n_limits  = 0;
  int unsigned n_checked = 0;
  int unsigned n_rejects = 0;
  int unsigned n_errors  = 0;
  int unsigned cycles    = 0;

  base58_encoder_core #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #1 clk = ~clk;

  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    int unsigned lim;
    int unsigned carry;
    int unsigned pos;
    int unsigned acc;
    int unsigned ones;
    int unsigned digs;
    int unsigned total;
    b58_out_t    ch;
    lim = (limit_reg == 7'd0) ? 1 : ((limit_reg > MAX_LEN) ? MAX_LEN : limit_reg);
    new_chars.delete();
    if (!rejected) begin
      carry = b;
      pos = 0;
      if (b == 8'd0 && leading) begin
        if (n_ones < MAX_LEN) n_ones++;
      end else begin
        leading = 1'b0;
      end
      while ((pos < n_digits || carry != 0) && !rejected) begin
        acc = carry;
        if (pos < n_digits) acc += 256 * digits[pos];
        carry = acc / 58;
        digits[pos] = 6'(acc % 58);
        pos++;
        if (pos > n_digits) n_digits = pos;
        if (pos >= lim) rejected = 1'b1;
      end
    end
    if (!fin) return;
    if (rejected) begin
      new_chars.push_back(b58_out_t'{B58_CH_ONE, 1'b1, 1'b1});
    end else begin
      ones = (n_ones < lim) ? n_ones : lim;
      digs = (n_digits < lim - ones) ? n_digits : lim - ones;
      total = ones + digs;
      for (int unsigned k = 0; k < total; k++) begin
        if (k < ones) begin
          ch.out_char = B58_CH_ONE;
        end else begin
          ch.out_char = 7'(alphabet[digits[n_digits - 1 - (k - ones)]]);
        end
        ch.last_char = (k + 1 == total);
        ch.overflow = 1'b0;
        new_chars.push_back(ch);
      end
    end
    n_digits = 0;
    n_ones = 0;
    leading = 1'b1;
    rejected = 1'b0;
  endfunction

  function automatic void flag_error(input string what, input b58_out_t want,
                                     input b58_out_t got);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%s: expected char %0d last %0b ovf %0b, got char %0d last %0b ovf %0b",
               what, want.out_char, want.last_char, want.overflow,
               got.out_char, got.last_char, got.overflow);
    end
  endfunction

  task automatic write_limit(input logic [6:0] value);
    in_valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (MAX_LEN + 8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_reg = value;
    n_limits++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin, input logic [2:0] n_typed,
                           input logic err, input logic [31:0] text);
    logic [7:0] code;
    int         nt;
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b58_in_t'{data_byte: b, last_byte: fin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_byte(b, fin);
    n_bytes++;
    if (fin) n_strings++;
    nt = n_typed;
    if (nt == 0) begin
      foreach (new_chars[i]) chars_due.push_back(new_chars[i]);
    end else begin
      for (int k = 0; k < nt; k++) begin
        code = text[8 * (nt - 1 - k) +: 8];
        chars_due.push_back(b58_out_t'{code[6:0], k == nt - 1, err});
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 27);
  end

  always @(posedge clk) begin : check_chars
    b58_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (chars_due.size() == 0) begin
        flag_error("character with nothing expected", '0, out_data);
      end else begin
        want = chars_due.pop_front();
        if (out_data.out_char !== want.out_char || out_data.last_char !== want.last_char ||
            out_data.overflow !== want.overflow) begin
          flag_error("wrong character", want, out_data);
        end
        n_checked++;
        if (want.overflow) n_rejects++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d characters outstanding.",
               cycles, chars_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0]  str_bytes [$];
    logic [6:0]  plan [8];
    int unsigned kind;
    int unsigned len;
    int unsigned zeros;
    int unsigned phase;
    int unsigned phase_start;
    int unsigned random_start;
    plan = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd5, 7'd30, 7'd64, 7'd12};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].set_cfg) write_limit(directed_rows[r].cfg_val);
      push_byte(directed_rows[r].data, directed_rows[r].fin, directed_rows[r].n_typed,
                directed_rows[r].err, directed_rows[r].text);
    end

    random_start = n_bytes;
    phase = 0;
    phase_start = n_bytes;
    write_limit(plan[0]);
    while (n_bytes - random_start < RANDOM_BYTES) begin
      if (n_bytes - phase_start >= PHASE_BYTES) begin
        phase++;
        phase_start = n_bytes;
        write_limit(phase < 8 ? plan[phase] : 7'($urandom_range(127)));
      end
      calm = (n_bytes - random_start >= 200) && (n_bytes - random_start < 300);
      str_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 60) begin
        zeros = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        len = $urandom_range(0, 10);
        if (zeros + len == 0) len = 1;
        repeat (zeros) str_bytes.push_back(8'h00);
        repeat (len) str_bytes.push_back(8'($urandom_range(255)));
      end else if (kind < 72) begin
        repeat ($urandom_range(40, 52)) str_bytes.push_back(8'($urandom));
      end else if (kind < 80) begin
        repeat ($urandom_range(60, 70)) str_bytes.push_back(8'h00);
        repeat ($urandom_range(0, 2)) str_bytes.push_back(8'($urandom));
      end else if (kind < 92) begin
        str_bytes.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) str_bytes.push_back($urandom_range(1) ? 8'hFF : 8'h00);
      end
      foreach (str_bytes[i]) begin
        push_byte(str_bytes[i], i == str_bytes.size() - 1, 3'd0, 1'b0, 32'd0);
      end
    end

    in_valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (2 * MAX_LEN + 8) @(posedge clk);
    $display("Encoded %0d bytes in %0d strings under %0d limit settings.",
             n_bytes, n_strings, n_limits);
    $display("Checked %0d characters, %0d of them rejected-string results, %0d errors.",
             n_checked, n_rejects, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- base58_encoder_core.f -----
sv/b58_pkg.sv
sv/b58_ctrl.sv
sv/b58_datapath.sv
sv/base58_encoder_core.sv
test/base58_encoder_core_test.sv
